>>> hw/rtl/ddarc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddarc_pkg
// Shared types, widths and tables for the grid raycaster.
// ----------------------------------------------------------------------------
package ddarc_pkg;

  // map geometry
  localparam int MAP_DIM   = 32;
  localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
  localparam int CELL_W    = $clog2(MAP_DIM);
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int CODE_W    = 3;

  // stream and config port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // datapath widths
  localparam int DIV_W  = 32;
  localparam int OFFQ_W = 25;
  localparam int OFF_W  = 27;
  localparam int PROD_W = 43;
  localparam int RAY_W  = 30;
  localparam int POS_W  = 10;
  localparam int SD_W   = 44;
  localparam int ONE_Q14 = 16384;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAYER_X       = 3'd0,
    CFG_PLAYER_Y       = 3'd1,
    CFG_VIEW_DIR_X     = 3'd2,
    CFG_VIEW_DIR_Y     = 3'd3,
    CFG_CAMERA_PLANE_X = 3'd4,
    CFG_CAMERA_PLANE_Y = 3'd5,
    CFG_SCREEN_COLUMNS = 3'd6,
    CFG_SCREEN_ROWS    = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_OFF_GO, S_OFF_WAIT, S_MUL_X, S_RAY_X, S_MUL_Y, S_RAY_Y,
    S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SIDE_X, S_SIDE_Y, S_WALK,
    S_STEP, S_READ, S_DIST, S_H_GO, S_H_WAIT, S_FIN, S_ESC
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LOAD, OP_DIV_OFF, OP_LATCH_OFF, OP_MUL_X, OP_RAY_X,
    OP_MUL_Y, OP_RAY_Y, OP_DIV_DX, OP_LATCH_DX, OP_DIV_DY, OP_LATCH_DY,
    OP_SIDE_X, OP_SIDE_Y, OP_STEP, OP_CHECK, OP_DIST, OP_DIV_H, OP_FINISH,
    OP_ESCAPE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic start_out;
    logic step_out;
    logic hit;
    logic out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] x,
                                                  input logic [CELL_W-1:0] y);
    return ADDR_W'(int'(x) * MAP_DIM + int'(y));
  endfunction

  // y-side hits use the darker shade
  function automatic logic [31:0] color_of(input logic [CODE_W-1:0] code,
                                           input logic side);
    logic [31:0] c;
    if (side) begin
      case (code)
        3'd1:    c = 32'hFFAA0000;
        3'd2:    c = 32'hFF00AA00;
        3'd3:    c = 32'hFF0000AA;
        3'd4:    c = 32'hFFAAAAAA;
        default: c = 32'hFFAAAA00;
      endcase
    end else begin
      case (code)
        3'd1:    c = 32'hFFFF0000;
        3'd2:    c = 32'hFF00FF00;
        3'd3:    c = 32'hFF0000FF;
        3'd4:    c = 32'hFFFFFFFF;
        default: c = 32'hFFFFFF00;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ddarc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddarc_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module ddarc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ddarc_pkg::DIV_W-1:0] num,
  input  wire logic [ddarc_pkg::DIV_W-1:0] den,
  output logic      [ddarc_pkg::DIV_W-1:0] quo,
  output logic                             done
);
  import ddarc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   shifted;
  logic             ge;

  assign shifted = {rem, quo[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? DIV_W'(shifted - {1'b0, den_r}) : shifted[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ddarc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddarc_ctrl
// Sequencer for map clear, cell writes and the per-column ray cast.
// ----------------------------------------------------------------------------
module ddarc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            s_tuser,
  output logic                 s_tready,
  input  wire ddarc_pkg::sts_t sts,
  output ddarc_pkg::cmd_t      cmd
);
  import ddarc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid && s_tuser == FUNC_CAST) state_next = S_OFF_GO;
      S_OFF_GO:   state_next = S_OFF_WAIT;
      S_OFF_WAIT: if (sts.div_done) state_next = S_MUL_X;
      S_MUL_X:    state_next = S_RAY_X;
      S_RAY_X:    state_next = S_MUL_Y;
      S_MUL_Y:    state_next = S_RAY_Y;
      S_RAY_Y:    state_next = S_DX_GO;
      S_DX_GO:    state_next = S_DX_WAIT;
      S_DX_WAIT:  if (sts.div_done) state_next = S_DY_GO;
      S_DY_GO:    state_next = S_DY_WAIT;
      S_DY_WAIT:  if (sts.div_done) state_next = S_SIDE_X;
      S_SIDE_X:   state_next = S_SIDE_Y;
      S_SIDE_Y:   state_next = S_WALK;
      S_WALK:     state_next = sts.start_out ? S_ESC : S_STEP;
      S_STEP:     state_next = sts.step_out ? S_ESC : S_READ;
      S_READ:     state_next = sts.hit ? S_DIST : S_STEP;
      S_DIST:     state_next = S_H_GO;
      S_H_GO:     state_next = S_H_WAIT;
      S_H_WAIT:   if (sts.div_done) state_next = S_FIN;
      S_FIN:      if (sts.out_free) state_next = S_IDLE;
      S_ESC:      if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NOP;
    s_tready = 1'b0;
    case (state)
      S_CLEAR:    cmd.op = OP_CLEAR;
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = OP_LOAD;
      end
      S_OFF_GO:   cmd.op = OP_DIV_OFF;
      S_OFF_WAIT: if (sts.div_done) cmd.op = OP_LATCH_OFF;
      S_MUL_X:    cmd.op = OP_MUL_X;
      S_RAY_X:    cmd.op = OP_RAY_X;
      S_MUL_Y:    cmd.op = OP_MUL_Y;
      S_RAY_Y:    cmd.op = OP_RAY_Y;
      S_DX_GO:    cmd.op = OP_DIV_DX;
      S_DX_WAIT:  if (sts.div_done) cmd.op = OP_LATCH_DX;
      S_DY_GO:    cmd.op = OP_DIV_DY;
      S_DY_WAIT:  if (sts.div_done) cmd.op = OP_LATCH_DY;
      S_SIDE_X:   cmd.op = OP_SIDE_X;
      S_SIDE_Y:   cmd.op = OP_SIDE_Y;
      S_STEP:     cmd.op = OP_STEP;
      S_READ:     cmd.op = OP_CHECK;
      S_DIST:     cmd.op = OP_DIST;
      S_H_GO:     cmd.op = OP_DIV_H;
      S_FIN:      if (sts.out_free) cmd.op = OP_FINISH;
      S_ESC:      if (sts.out_free) cmd.op = OP_ESCAPE;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/ddarc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddarc_dp
// Datapath: config registers, map memory, divider, ray setup, DDA walk and
// result register.
// ----------------------------------------------------------------------------
module ddarc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ddarc_pkg::cmd_t                   cmd,
  output ddarc_pkg::sts_t                        sts,
  input  wire logic [ddarc_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                              s_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [ddarc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ddarc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [ddarc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ddarc_pkg::*;

  // config registers
  logic        [15:0] player_x, player_y;
  logic signed [15:0] view_dir_x, view_dir_y, camera_plane_x, camera_plane_y;
  logic        [9:0]  screen_columns, screen_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x       <= 16'd5632;
      player_y       <= 16'd3072;
      view_dir_x     <= -16'sd16384;
      view_dir_y     <= 16'sd0;
      camera_plane_x <= 16'sd0;
      camera_plane_y <= 16'sd10813;
      screen_columns <= 10'd60;
      screen_rows    <= 10'd272;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLAYER_X:       player_x       <= cfg_data;
        CFG_PLAYER_Y:       player_y       <= cfg_data;
        CFG_VIEW_DIR_X:     view_dir_x     <= cfg_data;
        CFG_VIEW_DIR_Y:     view_dir_y     <= cfg_data;
        CFG_CAMERA_PLANE_X: camera_plane_x <= cfg_data;
        CFG_CAMERA_PLANE_Y: camera_plane_y <= cfg_data;
        CFG_SCREEN_COLUMNS: screen_columns <= cfg_data[9:0];
        CFG_SCREEN_ROWS:    screen_rows    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // input beat fields
  logic [4:0]        in_cell_x, in_cell_y;
  logic [CODE_W-1:0] in_cell_value;
  logic [9:0]        in_column;

  assign in_cell_x     = s_tdata[4:0];
  assign in_cell_y     = s_tdata[9:5];
  assign in_cell_value = s_tdata[12:10];
  assign in_column     = s_tdata[22:13];

  // map memory with clearing pass after reset
  logic [CODE_W-1:0] grid_map [MAP_CELLS];
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CODE_W-1:0] mem_rdata;
  logic              wr_in_map;

  assign wr_in_map = (int'(in_cell_x) < MAP_DIM) && (int'(in_cell_y) < MAP_DIM);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (cmd.op == OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd.op == OP_LOAD && s_tuser == FUNC_WRITE && wr_in_map) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(CELL_W'(in_cell_x), CELL_W'(in_cell_y));
      mem_wdata = in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_map[mem_waddr] <= mem_wdata;
    mem_rdata <= grid_map[mem_raddr];
  end

  // divider and its operand select
  logic             div_start;
  logic [DIV_W-1:0] div_num, div_den, div_quo;
  logic             div_done;

  logic signed [RAY_W-1:0] rdx, rdy;
  logic        [RAY_W-1:0] mag_x, mag_y;
  logic [9:0]              col;
  logic [DIV_W-1:0]        wall_dist;

  assign mag_x = rdx[RAY_W-1] ? RAY_W'(-rdx) : RAY_W'(rdx);
  assign mag_y = rdy[RAY_W-1] ? RAY_W'(-rdy) : RAY_W'(rdy);

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DIV_OFF: begin
        div_num = {7'd0, col, 15'd0};
        div_den = {22'd0, (screen_columns == 10'd0) ? 10'd1 : screen_columns};
      end
      OP_DIV_DX: begin
        div_num = 32'h4000_0000;
        div_den = {2'd0, mag_x};
      end
      OP_DIV_DY: begin
        div_num = 32'h4000_0000;
        div_den = {2'd0, mag_y};
      end
      OP_DIV_H: begin
        div_num = {6'd0, screen_rows, 16'd0};
        div_den = wall_dist;
      end
      default: div_start = 1'b0;
    endcase
  end

  ddarc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // ray setup
  logic        [OFFQ_W-1:0] q_off;
  logic signed [OFF_W-1:0]  off;
  logic signed [15:0]       plane_sel, dir_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [RAY_W-1:0]  ray_sum;

  assign off       = $signed({2'b00, q_off}) - OFF_W'(ONE_Q14);
  assign plane_sel = (cmd.op == OP_MUL_Y) ? camera_plane_y : camera_plane_x;
  assign dir_sel   = (cmd.op == OP_RAY_Y) ? view_dir_y : view_dir_x;
  // arithmetic shift gives the floor of the Q2.14 product
  assign ray_sum   = RAY_W'(dir_sel) + RAY_W'(prod >>> 14);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:      col   <= in_column;
      OP_LATCH_OFF: q_off <= div_quo[OFFQ_W-1:0];
      OP_MUL_X,
      OP_MUL_Y:     prod  <= PROD_W'(plane_sel) * PROD_W'(off);
      OP_RAY_X:     rdx   <= ray_sum;
      OP_RAY_Y:     rdy   <= ray_sum;
      default: ;
    endcase
  end

  // DDA walk
  logic [DIV_W-1:0]        dx, dy;
  logic signed [POS_W-1:0] mx, my, mx_n, my_n;
  logic [SD_W-1:0]         sx, sy;
  logic                    side;
  logic [CODE_W-1:0]       code;
  logic [8:0]              frac_sel;
  logic [DIV_W-1:0]        delta_sel;
  logic [40:0]             side_prod;
  logic                    neg_sel;
  logic [7:0]              pos_frac;
  logic                    step_x;
  logic [SD_W-1:0]         dist_raw;

  assign neg_sel   = (cmd.op == OP_SIDE_Y) ? rdy[RAY_W-1] : rdx[RAY_W-1];
  assign pos_frac  = (cmd.op == OP_SIDE_Y) ? player_y[7:0] : player_x[7:0];
  assign delta_sel = (cmd.op == OP_SIDE_Y) ? dy : dx;
  assign frac_sel  = neg_sel ? {1'b0, pos_frac} : 9'd256 - {1'b0, pos_frac};
  assign side_prod = 41'(frac_sel) * 41'(delta_sel);

  assign step_x = sx < sy;

  always_comb begin
    mx_n = mx;
    my_n = my;
    if (step_x) begin
      mx_n = rdx[RAY_W-1] ? mx - 1'b1 : mx + 1'b1;
    end else begin
      my_n = rdy[RAY_W-1] ? my - 1'b1 : my + 1'b1;
    end
  end

  assign mem_raddr = cell_addr(mx_n[CELL_W-1:0], my_n[CELL_W-1:0]);
  assign dist_raw  = side ? sy - SD_W'(dy) : sx - SD_W'(dx);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH_DX: dx <= div_quo;
      OP_LATCH_DY: dy <= div_quo;
      OP_SIDE_X: begin
        sx <= SD_W'(side_prod >> 8);
        mx <= POS_W'({2'b00, player_x[15:8]});
      end
      OP_SIDE_Y: begin
        sy <= SD_W'(side_prod >> 8);
        my <= POS_W'({2'b00, player_y[15:8]});
      end
      OP_STEP: begin
        mx   <= mx_n;
        my   <= my_n;
        side <= !step_x;
        if (step_x) sx <= sx + SD_W'(dx);
        else        sy <= sy + SD_W'(dy);
      end
      OP_CHECK: code <= mem_rdata;
      OP_DIST:  wall_dist <= (|dist_raw[SD_W-1:DIV_W]) ? '1 : dist_raw[DIV_W-1:0];
      default: ;
    endcase
  end

  // height, start and result register
  logic [9:0]        height;
  logic signed [10:0] rem_rows;
  logic [9:0]        line_start;

  assign height     = (|div_quo[DIV_W-1:10]) ? 10'd1023 : div_quo[9:0];
  assign rem_rows   = $signed({1'b0, screen_rows}) - $signed({1'b0, height[9:1], 1'b0});
  assign line_start = rem_rows[10] ? 10'd0 : {1'b0, rem_rows[9:1]};

  logic [9:0]        o_column, o_start, o_height;
  logic [CODE_W-1:0] o_code;
  logic              o_side, o_escaped;
  logic [31:0]       o_color, o_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_FINISH || cmd.op == OP_ESCAPE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      o_column  <= col;
      o_start   <= line_start;
      o_height  <= height;
      o_code    <= code;
      o_side    <= side;
      o_color   <= color_of(code, side);
      o_dist    <= wall_dist;
      o_escaped <= 1'b0;
    end else if (cmd.op == OP_ESCAPE) begin
      o_column  <= col;
      o_start   <= '0;
      o_height  <= '0;
      o_code    <= '0;
      o_side    <= 1'b0;
      o_color   <= '0;
      o_dist    <= '0;
      o_escaped <= 1'b1;
    end
  end

  assign m_tdata = {5'd0, o_escaped, o_dist, o_color, o_side, o_code,
                    o_height, o_start, o_column};

  assign sts.div_done  = div_done;
  assign sts.clr_last  = (clr_addr == ADDR_W'(MAP_CELLS - 1));
  assign sts.start_out = (mx >= MAP_DIM) || (my >= MAP_DIM);
  assign sts.step_out  = (mx_n < 0) || (mx_n >= MAP_DIM) || (my_n < 0) ||
                         (my_n >= MAP_DIM);
  assign sts.hit       = (mem_rdata != '0);
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule
`default_nettype wire

>>> hw/rtl/dda_column_raycaster_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_column_raycaster_top
// Grid map raycaster: map cell writes and per-column DDA ray casts.
// ----------------------------------------------------------------------------
// After reset the block clears the 32x32 map to open cells and takes no
// beat in that time; config writes are taken throughout. A map write beat
// is written from the idle state, so writes stream back to back. A cast
// beat steps the ray through N cells, N being at most about 2*MAP_DIM, and
// makes four passes through the one-bit-per-cycle 32-bit divider (plane
// offset, the two reciprocals, the line height); each grid step has one
// state to step and one for the registered map read. A finished result sits
// in the output register while the next beat is taken.
module dda_column_raycaster_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // cell_x[4:0], cell_y[9:5], cell_value[12:10], column[22:13]
  input  wire logic [ddarc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // out_column[9:0], line_start[19:10], line_height[29:20], wall_code[32:30],
  // hit_side[33], wall_color[65:34], wall_distance[97:66], escaped[98]
  output logic      [ddarc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [ddarc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ddarc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ddarc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ddarc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddarc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

>>> dv/dda_column_raycaster_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_column_raycaster_checker
// Watches the input, output and config channels of the raycaster, keeps its
// own copy of the map and registers, predicts each cast result and compares
// it with what comes out.
// ----------------------------------------------------------------------------
module dda_column_raycaster_checker
  import ddarc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                   s_tuser,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        escaped;
    logic [31:0] distance;
    logic [31:0] color;
    logic        side;
    logic [2:0]  code;
    logic [9:0]  height;
    logic [9:0]  start;
    logic [9:0]  column;
  } cast_result_t;

  logic [15:0] pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  logic [9:0]  n_cols, n_rows;
  logic [2:0]  cells [MAP_CELLS];
  cast_result_t casts_due[$];

  function automatic longint fl14(longint v);
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function automatic longint inv_mag(longint r);
    longint m;
    m = r < 0 ? -r : r;
    if (m == 0) return 64'hFFFF_FFFF;
    return (64'd1 << 30) / m;
  endfunction

  function automatic cast_result_t trace_column(logic [9:0] col);
    cast_result_t r;
    longint cols, off, rx, ry, ddx, ddy, mx, my, sx, sy, stx, sty, fx, fy;
    longint perp, h, n;
    logic side, esc;
    logic [2:0] code;
    cols = n_cols == 0 ? 1 : n_cols;
    off = (longint'(col) * 2 * ONE_Q14) / cols - ONE_Q14;
    rx = longint'($signed(dir_x)) + fl14(longint'($signed(plane_x)) * off);
    ry = longint'($signed(dir_y)) + fl14(longint'($signed(plane_y)) * off);
    ddx = inv_mag(rx);
    ddy = inv_mag(ry);
    mx = pos_x[15:8];
    my = pos_y[15:8];
    fx = pos_x[7:0];
    fy = pos_y[7:0];
    if (rx < 0) begin stx = -1; sx = (fx * ddx) >> 8; end
    else begin stx = 1; sx = ((256 - fx) * ddx) >> 8; end
    if (ry < 0) begin sty = -1; sy = (fy * ddy) >> 8; end
    else begin sty = 1; sy = ((256 - fy) * ddy) >> 8; end
    esc = (mx >= MAP_DIM || my >= MAP_DIM);
    side = 1'b0;
    code = 3'd0;
    while (!esc) begin
      if (sx < sy) begin
        sx += ddx; mx += stx; side = 1'b0;
      end else begin
        sy += ddy; my += sty; side = 1'b1;
      end
      if (mx < 0 || mx >= MAP_DIM || my < 0 || my >= MAP_DIM) begin
        esc = 1'b1;
        break;
      end
      code = cells[mx * MAP_DIM + my];
      if (code != 0) break;
    end
    r = '0;
    r.column = col;
    if (esc) begin
      r.escaped = 1'b1;
      return r;
    end
    perp = side ? sy - ddy : sx - ddx;
    if (perp > 64'hFFFF_FFFF) perp = 64'hFFFF_FFFF;
    if (perp == 0) h = 1023;
    else begin
      h = (longint'(n_rows) << 16) / perp;
      if (h > 1023) h = 1023;
    end
    n = longint'(n_rows) - 2 * (h >> 1);
    r.start = n < 0 ? 10'd0 : 10'(n >> 1);
    r.height = 10'(h);
    r.code = code;
    r.side = side;
    r.color = color_of(code, side);
    r.distance = 32'(perp);
    return r;
  endfunction

  assign pending = casts_due.size();

  always_ff @(posedge clk) begin
    cast_result_t want, got;
    if (rst) begin
      pos_x <= 16'd5632; pos_y <= 16'd3072; dir_x <= 16'hC000; dir_y <= '0;
      plane_x <= '0; plane_y <= 16'd10813; n_cols <= 10'd60; n_rows <= 10'd272;
      foreach (cells[i]) cells[i] = '0;
      casts_due.delete();
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = cast_result_t'(m_tdata[98:0]);
        if (casts_due.size() == 0) begin
          $display("%t: unexpected result beat, expected none, actual %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = casts_due.pop_front();
          if (got !== want) begin
            $display("%t: result mismatch col %0d, expected %h, actual %h",
                     $realtime, want.column, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_CAST) casts_due.push_back(trace_column(s_tdata[22:13]));
        else cells[cell_addr(s_tdata[4:0], s_tdata[9:5])] = s_tdata[12:10];
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PLAYER_X:       pos_x <= cfg_data;
          CFG_PLAYER_Y:       pos_y <= cfg_data;
          CFG_VIEW_DIR_X:     dir_x <= cfg_data;
          CFG_VIEW_DIR_Y:     dir_y <= cfg_data;
          CFG_CAMERA_PLANE_X: plane_x <= cfg_data;
          CFG_CAMERA_PLANE_Y: plane_y <= cfg_data;
          CFG_SCREEN_COLUMNS: n_cols <= cfg_data[9:0];
          CFG_SCREEN_ROWS:    n_rows <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_dda_column_raycaster_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_dda_column_raycaster_top
// Drives map writes, column casts and register settings into the raycaster
// under random sender and receiver idling; the checker judges each result.
// ----------------------------------------------------------------------------
module tb_dda_column_raycaster_top;
  import ddarc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0, cfg_we = 0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tready, m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dda_column_raycaster_top dut (.*);
  dda_column_raycaster_checker chk (.*);

  // receiver stalls at random
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // valid stays up after a beat until the next call idles or sends
  task automatic send_beat(logic func, logic [4:0] x, logic [4:0] y, logic [2:0] v,
                           logic [9:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= func;
    s_tdata <= {1'b0, col, v, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic cast_col(logic [9:0] col);
    send_beat(FUNC_CAST, 5'($urandom), 5'($urandom), 3'($urandom), col);
  endtask

  task automatic put_cell(logic [4:0] x, logic [4:0] y, logic [2:0] v);
    send_beat(FUNC_WRITE, x, y, v, 10'($urandom));
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // border ring of walls plus random interior blocks
  task automatic build_room;
    for (int i = 0; i < MAP_DIM; i++) begin
      put_cell(5'(i), 5'd0, 3'($urandom_range(1, 7)));
      put_cell(5'(i), 5'(MAP_DIM - 1), 3'($urandom_range(1, 7)));
      put_cell(5'd0, 5'(i), 3'($urandom_range(1, 7)));
      put_cell(5'(MAP_DIM - 1), 5'(i), 3'($urandom_range(1, 7)));
    end
    repeat (40) put_cell(5'($urandom_range(1, 30)), 5'($urandom_range(1, 30)),
                         3'($urandom));
  endtask

  task automatic random_view;
    set_reg(CFG_PLAYER_X, {8'($urandom_range(2, 29)), 8'($urandom)});
    set_reg(CFG_PLAYER_Y, {8'($urandom_range(2, 29)), 8'($urandom)});
    set_reg(CFG_VIEW_DIR_X, 16'($urandom));
    set_reg(CFG_VIEW_DIR_Y, 16'($urandom));
    set_reg(CFG_CAMERA_PLANE_X, 16'($urandom));
    set_reg(CFG_CAMERA_PLANE_Y, 16'($urandom));
    set_reg(CFG_SCREEN_COLUMNS, 16'($urandom_range(0, 1023)));
    set_reg(CFG_SCREEN_ROWS, 16'($urandom_range(0, 1023)));
  endtask

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 45;
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed: default view over open map, then with wall cells placed
    cast_col(10'd0);
    cast_col(10'd30);
    cast_col(10'd1023);
    put_cell(5'd31, 5'd31, 3'd7);
    put_cell(5'd31, 5'd0, 3'd0);
    for (int v = 1; v < 8; v++) put_cell(5'(10 - v), 5'd12, 3'(v));
    put_cell(5'd22, 5'd20, 3'd4);
    cast_col(10'd59);
    cast_col(10'd60);
    drain();
    // extremes: zero dir component, player off map, zero rows and columns
    set_reg(CFG_CAMERA_PLANE_Y, 16'h0000);
    set_reg(CFG_SCREEN_ROWS, 16'd0);
    set_reg(CFG_SCREEN_COLUMNS, 16'd0);
    cast_col(10'd0);
    cast_col(10'd1);
    drain();
    set_reg(CFG_PLAYER_X, 16'hFFFF);
    set_reg(CFG_PLAYER_Y, 16'h0000);
    set_reg(CFG_VIEW_DIR_X, 16'h7FFF);
    set_reg(CFG_VIEW_DIR_Y, 16'h8000);
    set_reg(CFG_CAMERA_PLANE_X, 16'h8000);
    set_reg(CFG_CAMERA_PLANE_Y, 16'h7FFF);
    set_reg(CFG_SCREEN_ROWS, 16'd1023);
    set_reg(CFG_SCREEN_COLUMNS, 16'd1023);
    cast_col(10'd512);
    drain();
    set_reg(CFG_PLAYER_X, 16'h0A80);
    set_reg(CFG_PLAYER_Y, 16'h0C00);
    set_reg(CFG_SCREEN_COLUMNS, 16'd1);
    cast_col(10'd1023);
    cast_col(10'd0);
    drain();
    build_room();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 45; recv_idle_pct = 28; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        random_view();
        for (int k = 0; k < 100; k++) begin
          if ($urandom_range(9) < 2) put_cell(5'($urandom), 5'($urandom), 3'($urandom));
          else cast_col(10'($urandom_range(0, 1023)));
        end
        if (blk == 1) build_room();
      end
    end
    drain();
    if (fail_count == 0) $display("dda_column_raycaster_top regression: pass");
    else $display("dda_column_raycaster_top regression: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("dda_column_raycaster_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> dda_column_raycaster_top.f
hw/rtl/ddarc_pkg.sv
hw/rtl/ddarc_div.sv
hw/rtl/ddarc_ctrl.sv
hw/rtl/ddarc_dp.sv
hw/rtl/dda_column_raycaster_top.sv
dv/dda_column_raycaster_checker.sv
dv/tb_dda_column_raycaster_top.sv
